[hdl/sbus_enc_pkg.sv]
// ----------------------------------------------------------------------------
// sbus_enc_pkg
// Types and constants shared by the SBUS frame encoder.
// ----------------------------------------------------------------------------
package sbus_enc_pkg;

    localparam int NUM_CHANNELS_DEF     = 16;
    localparam int BITS_PER_CHANNEL_DEF = 11;

    localparam int         DATA_LEN    = 22;
    localparam logic [7:0] START_BYTE  = 8'h0F;
    localparam logic [7:0] STOP_BYTE   = 8'h00;
    localparam logic [7:0] FLAGS_RESET = 8'h03;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  channel;
        logic [15:0] value;
    } t_in;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DATA,
        ST_FLAGS,
        ST_STOP
    } t_state;

endpackage

[hdl/sbus_frame_encoder_core.sv]
// ----------------------------------------------------------------------------
// sbus_frame_encoder_core
// Stores servo channel values and streams 25-byte SBUS frames on request.
// ----------------------------------------------------------------------------
// set beat: no output, next beat accepted in the next cycle
// send beat: first byte goes from the START state to the output register; 25
//   output beats, with one channel at a time loaded into the shared bit packer
//   between them, input stalled until the stop byte is issued
// reset (synchronous, active low): channel values zero, flags byte 0x03
// ----------------------------------------------------------------------------
module sbus_frame_encoder_core #(
    parameter int NUM_CHANNELS     = sbus_enc_pkg::NUM_CHANNELS_DEF,
    parameter int BITS_PER_CHANNEL = sbus_enc_pkg::BITS_PER_CHANNEL_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sbus_enc_pkg::t_in  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output sbus_enc_pkg::t_out o_data,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data
);

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHC_W = $clog2(NUM_CHANNELS + 1);
    localparam int BUF_W = BITS_PER_CHANNEL + 8;
    localparam int CNT_W = $clog2(BUF_W + 1);
    localparam int BYT_W = $clog2(sbus_enc_pkg::DATA_LEN);

    logic [BITS_PER_CHANNEL-1:0] r_chan [NUM_CHANNELS];
    logic [7:0]                  r_flags;

    sbus_enc_pkg::t_state r_state, n_state;
    logic [BUF_W-1:0]     r_buf, n_buf;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CHC_W-1:0]     r_ch, n_ch;
    logic [BYT_W-1:0]     r_byte, n_byte;
    logic                 r_out_valid, n_out_valid;
    sbus_enc_pkg::t_out   r_out, n_out;

    logic in_take;
    logic can_push;
    logic set_hit;

    assign o_stall  = (r_state != sbus_enc_pkg::ST_IDLE);
    assign in_take  = i_valid && !o_stall;
    assign can_push = !r_out_valid || !i_stall;
    assign set_hit  = in_take && (i_data.cmd == sbus_enc_pkg::CMD_SET)
                      && ({24'd0, i_data.channel} < 32'(NUM_CHANNELS));
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_comb begin
        n_state     = r_state;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_ch        = r_ch;
        n_byte      = r_byte;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;

        case (r_state)
            sbus_enc_pkg::ST_IDLE: begin
                if (in_take && i_data.cmd == sbus_enc_pkg::CMD_SEND) begin
                    n_state = sbus_enc_pkg::ST_START;
                    n_buf   = '0;
                    n_cnt   = '0;
                    n_ch    = '0;
                    n_byte  = '0;
                end
            end
            sbus_enc_pkg::ST_START: begin
                if (can_push) begin
                    n_out_valid      = 1'b1;
                    n_out.frame_byte = sbus_enc_pkg::START_BYTE;
                    n_out.last       = 1'b0;
                    n_state          = sbus_enc_pkg::ST_DATA;
                end
            end
            sbus_enc_pkg::ST_DATA: begin
                if (r_cnt < CNT_W'(8) && r_ch < CHC_W'(NUM_CHANNELS)) begin
                    // append the next channel above the bits still pending
                    n_buf = r_buf | (BUF_W'(r_chan[r_ch[CH_W-1:0]]) << r_cnt);
                    n_cnt = r_cnt + CNT_W'(BITS_PER_CHANNEL);
                    n_ch  = r_ch + CHC_W'(1);
                end else if (can_push) begin
                    n_out_valid      = 1'b1;
                    n_out.frame_byte = r_buf[7:0];
                    n_out.last       = 1'b0;
                    n_buf            = r_buf >> 8;
                    n_cnt            = (r_cnt >= CNT_W'(8)) ? r_cnt - CNT_W'(8) : '0;
                    n_byte           = r_byte + BYT_W'(1);
                    if (r_byte == BYT_W'(sbus_enc_pkg::DATA_LEN - 1)) begin
                        n_state = sbus_enc_pkg::ST_FLAGS;
                    end
                end
            end
            sbus_enc_pkg::ST_FLAGS: begin
                if (can_push) begin
                    n_out_valid      = 1'b1;
                    n_out.frame_byte = r_flags;
                    n_out.last       = 1'b0;
                    n_state          = sbus_enc_pkg::ST_STOP;
                end
            end
            sbus_enc_pkg::ST_STOP: begin
                if (can_push) begin
                    n_out_valid      = 1'b1;
                    n_out.frame_byte = sbus_enc_pkg::STOP_BYTE;
                    n_out.last       = 1'b1;
                    n_state          = sbus_enc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sbus_enc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbus_enc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf  <= n_buf;
        r_cnt  <= n_cnt;
        r_ch   <= n_ch;
        r_byte <= n_byte;
        r_out  <= n_out;
    end

    // channel store and flags register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_chan[k] <= '0;
            end
            r_flags <= sbus_enc_pkg::FLAGS_RESET;
        end else begin
            if (set_hit) begin
                r_chan[i_data.channel[CH_W-1:0]] <= i_data.value[BITS_PER_CHANNEL-1:0];
            end
            if (i_cfg_we) begin
                r_flags <= i_cfg_data;
            end
        end
    end

endmodule
